// ----- rtl/dcq_pkg.sv -----
// ============================================================================
// dcq_pkg: shared types and constants of the deduplicating task queue
// Holds the sizes, operation and status codes, and the transaction structs.
// ============================================================================
`default_nettype none

package dcq_pkg;

  localparam int NUM_SOCKETS      = 4;
  localparam int SLOTS_PER_SOCKET = 16;
  localparam int NUM_SLOTS        = 64;

  typedef enum logic [1:0] {
    FUNC_ADD         = 2'd0,
    FUNC_POP         = 2'd1,
    FUNC_CLEAR_ALL   = 2'd2,
    FUNC_CLEAR_BLOCK = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    func_t      func;
    logic [1:0] socket_id;
    logic [3:0] command;
  } dcq_in_t;

  typedef struct packed {
    status_t    status;
    logic       head_valid;
    logic [1:0] head_socket;
    logic [3:0] head_command;
  } dcq_result_t;

  // One slot of the queue.
  typedef struct packed {
    logic       valid;
    logic [1:0] socket;
    logic [3:0] command;
  } slot_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic       pop;
    logic       clear_all;
    logic       clear_blk;
    logic [1:0] blk_socket;
    logic [1:0] socket;
    logic [3:0] command;
  } cell_ctl_t;

  // Outcome of the scan, gathered over the row of cells.
  typedef struct packed {
    logic hit_dup;
    logic hit_add;
    logic scan_out;
  } scan_res_t;

endpackage

`default_nettype wire

// ----- rtl/dcq_cell.sv -----
// ============================================================================
// dcq_cell: one slot of the task queue
// Holds one task, takes its upper neighbor on a pop, and passes the add probe.
// ============================================================================
`default_nettype none

module dcq_cell (
  input  wire                       clk,
  input  wire                       rst,
  input  wire dcq_pkg::cell_ctl_t   ctl,
  input  wire                       wipe,
  input  wire                       token_in,
  input  wire dcq_pkg::slot_t       up_slot,
  output dcq_pkg::slot_t            slot,
  output logic                      token_out,
  output logic                      hit_dup,
  output logic                      hit_add
);

  logic match;

  assign match   = slot.valid && (slot.socket == ctl.socket) && (slot.command == ctl.command);
  assign hit_dup = token_in && match;
  assign hit_add = token_in && !slot.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= '0;
      token_out <= 1'b0;
    end else begin
      // pass the probe on past a valid slot that holds another task
      token_out <= token_in && slot.valid && !match;
      if (wipe) begin
        slot <= '0;
      end else if (ctl.pop) begin
        slot <= up_slot;
      end else if (hit_add) begin
        slot.valid   <= 1'b1;
        slot.socket  <= ctl.socket;
        slot.command <= ctl.command;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dcq_ctrl.sv -----
// ============================================================================
// dcq_ctrl: operation sequencer of the task queue
// Decodes operations, launches the add probe and forms the status.
// ============================================================================
`default_nettype none

module dcq_ctrl (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       start,
  input  wire dcq_pkg::dcq_in_t     item,
  input  wire dcq_pkg::scan_res_t   scan,
  output logic                      busy,
  output dcq_pkg::cell_ctl_t        ctl,
  output logic                      token0,
  output logic                      done,
  output dcq_pkg::status_t          status
);

  dcq_pkg::state_t  state, state_next;
  logic             done_next;
  logic             token0_next;
  dcq_pkg::status_t status_next;
  logic [1:0]       op_socket, op_socket_next;
  logic [3:0]       op_command, op_command_next;
  logic             accept;
  logic             sock_ok;

  assign accept  = start && (state == dcq_pkg::S_IDLE);
  assign sock_ok = int'(item.socket_id) < dcq_pkg::NUM_SOCKETS;
  assign busy    = (state == dcq_pkg::S_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= dcq_pkg::S_IDLE;
      done   <= 1'b0;
      token0 <= 1'b0;
    end else begin
      state  <= state_next;
      done   <= done_next;
      token0 <= token0_next;
    end
  end

  always_ff @(posedge clk) begin
    status     <= status_next;
    op_socket  <= op_socket_next;
    op_command <= op_command_next;
  end

  always_comb begin
    state_next      = state;
    done_next       = 1'b0;
    token0_next     = 1'b0;
    status_next     = status;
    op_socket_next  = op_socket;
    op_command_next = op_command;
    ctl             = '0;
    ctl.socket      = op_socket;
    ctl.command     = op_command;
    ctl.blk_socket  = item.socket_id;
    unique case (state)
      dcq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (item.func)
            dcq_pkg::FUNC_ADD: begin
              if (item.command == '0 || !sock_ok) begin
                done_next   = 1'b1;
                status_next = dcq_pkg::ST_DONE;
              end else begin
                state_next      = dcq_pkg::S_SCAN;
                token0_next     = 1'b1;
                op_socket_next  = item.socket_id;
                op_command_next = item.command;
              end
            end
            dcq_pkg::FUNC_POP: begin
              ctl.pop     = 1'b1;
              done_next   = 1'b1;
              status_next = dcq_pkg::ST_DONE;
            end
            dcq_pkg::FUNC_CLEAR_ALL: begin
              ctl.clear_all = 1'b1;
              done_next     = 1'b1;
              status_next   = dcq_pkg::ST_DONE;
            end
            dcq_pkg::FUNC_CLEAR_BLOCK: begin
              ctl.clear_blk = sock_ok;
              done_next     = 1'b1;
              status_next   = dcq_pkg::ST_DONE;
            end
            default: begin
              done_next   = 1'b1;
              status_next = dcq_pkg::ST_DONE;
            end
          endcase
        end
      end
      dcq_pkg::S_SCAN: begin
        if (scan.hit_dup) begin
          state_next  = dcq_pkg::S_IDLE;
          done_next   = 1'b1;
          status_next = dcq_pkg::ST_DUP;
        end else if (scan.hit_add) begin
          state_next  = dcq_pkg::S_IDLE;
          done_next   = 1'b1;
          status_next = dcq_pkg::ST_ADDED;
        end else if (scan.scan_out) begin
          state_next  = dcq_pkg::S_IDLE;
          done_next   = 1'b1;
          status_next = dcq_pkg::ST_FULL;
        end
      end
      default: begin
        state_next = dcq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/dedup_command_task_queue_unit.sv -----
// ============================================================================
// dedup_command_task_queue_unit: deduplicating queue of (socket, command) tasks
// A row of slot cells with a small sequencer in front of it.
// ============================================================================
// A transaction is accepted at a rising edge with start high and busy low.
// Its result is marked by done, which is high for exactly one cycle, in the
// cycle after the operation finishes; the receiver cannot stall it, so sample
// result whenever done is high. Pop, clear-all and clear-block finish at the
// accepting edge: done rises at that same edge and busy never rises, so these
// operations can be issued every cycle. An add sends a probe down the row of
// cells, one slot per cycle: busy stays high until the probe stops at a
// duplicate or an empty slot, or leaves the last cell when the queue is full,
// and done rises at the edge at which busy falls. The head fields always
// show slot 0 as it stands after the operation. A null-command add or an
// out-of-range socket changes nothing and reports "operation done" at once.
// ============================================================================
`default_nettype none

module dedup_command_task_queue_unit (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire dcq_pkg::dcq_in_t        item,
  output logic                         busy,
  output logic                         done,
  output dcq_pkg::dcq_result_t         result
);

  localparam int N = dcq_pkg::NUM_SLOTS;

  dcq_pkg::cell_ctl_t ctl;
  dcq_pkg::scan_res_t scan;
  dcq_pkg::status_t   status;
  dcq_pkg::slot_t     slots [N+1];
  logic [N:0]         tokens;
  logic [N-1:0]       dup_vec;
  logic [N-1:0]       add_vec;
  logic [N-1:0]       wipe_vec;

  // sequencer: decode, launch the probe, hold the status
  dcq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .scan   (scan),
    .busy   (busy),
    .ctl    (ctl),
    .token0 (tokens[0]),
    .done   (done),
    .status (status)
  );

  // an empty slot shifts in above the last cell on a pop
  assign slots[N] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    // wipe on clear-all, or when this slot lies in the addressed socket block
    assign wipe_vec[i] = ctl.clear_all ||
                         (ctl.clear_blk &&
                          (int'(ctl.blk_socket) == (i / dcq_pkg::SLOTS_PER_SOCKET)));

    dcq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .wipe      (wipe_vec[i]),
      .token_in  (tokens[i]),
      .up_slot   (slots[i+1]),
      .slot      (slots[i]),
      .token_out (tokens[i+1]),
      .hit_dup   (dup_vec[i]),
      .hit_add   (add_vec[i])
    );
  end

  // gather the probe outcome; a probe leaving the last cell means full
  assign scan.hit_dup  = |dup_vec;
  assign scan.hit_add  = |add_vec;
  assign scan.scan_out = tokens[N];

  // head comes straight from slot 0; empty slots hold zeros, gate anyway
  assign result.status       = status;
  assign result.head_valid   = slots[0].valid;
  assign result.head_socket  = slots[0].valid ? slots[0].socket : 2'd0;
  assign result.head_command = slots[0].valid ? slots[0].command : 4'd0;

endmodule

`default_nettype wire
